### sv/pph_pkg.sv
`timescale 1ns / 1ps

package pph_pkg;

   localparam int unsigned TimeoutWidth = 16;
   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned KindWidth    = 2;

   localparam logic [TimeoutWidth-1:0] TimeoutReset = TimeoutWidth'(1000);

   typedef logic [KindWidth-1:0] kind_type;

   localparam kind_type KindSample = 2'd0;
   localparam kind_type KindRead   = 2'd1;
   localparam kind_type KindWrite  = 2'd2;

   typedef struct packed {
      kind_type               kind;
      logic [ByteWidth-1:0]   write_byte;
      logic                   ms_tick;
      logic                   busy_line;
      logic                   ack_line;
      logic [ByteWidth-1:0]   data_in;
   } item_type;

   typedef struct packed {
      logic                   strobe_out;
      logic                   autofeed_out;
      logic                   data_drive;
      logic [ByteWidth-1:0]   data_out;
      logic                   done_res;
      logic                   success;
      logic [ByteWidth-1:0]   read_result;
      logic                   in_progress;
   } result_type;

endpackage

### sv/parallel_port_handshake_unit.sv
`timescale 1ns / 1ps

// Byte-wide parallel-port handshake engine. Each req transaction is one sample of the
// BUSY/ACK status lines, the data pins and a millisecond tick, optionally with a read or
// write command; each one yields exactly one rsp transaction giving the control line
// levels after that sample, plus done/success and the read byte at the end of a
// transfer. A new transaction is taken every cycle unless the rsp side stalls; each
// passes an input register, then a result register, and the rate is set by the
// handshake update between them. Commands arriving during a transfer are ignored.
// csr_timeout_ms may be written only while the engine is idle and all rsp transactions
// have been taken; a value of zero acts as one.
module parallel_port_handshake_unit (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  pph_pkg::kind_type             req_kind,
   input  logic [pph_pkg::ByteWidth-1:0] req_write_byte,
   input  logic                          req_ms_tick,
   input  logic                          req_busy_line,
   input  logic                          req_ack_line,
   input  logic [pph_pkg::ByteWidth-1:0] req_data_in,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_strobe_out,
   output logic                          rsp_autofeed_out,
   output logic                          rsp_data_drive,
   output logic [pph_pkg::ByteWidth-1:0] rsp_data_out,
   output logic                          rsp_done_res,
   output logic                          rsp_success,
   output logic [pph_pkg::ByteWidth-1:0] rsp_read_result,
   output logic                          rsp_in_progress,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pph_pkg::TimeoutWidth-1:0] csr_timeout_ms
);
   import pph_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_R_BUSY_HI,
      PH_R_BUSY_LO,
      PH_W_ACK_HI,
      PH_W_ACK_LO
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [TimeoutWidth-1:0]   countdown_ff, countdown_in;
   logic                      strobe_ff, strobe_in;
   logic                      autofeed_ff, autofeed_in;
   logic                      drive_ff, drive_in;
   logic [ByteWidth-1:0]      out_byte_ff, out_byte_in;
   logic [ByteWidth-1:0]      pending_ff, pending_in;
   logic [TimeoutWidth-1:0]   timeout_ff;

   logic                      item_valid_ff;
   item_type                  item_ff;
   logic                      rsp_valid_ff;
   result_type                rsp_ff, rsp_in;

   logic                      advance;
   logic                      expired;
   logic [TimeoutWidth-1:0]   tick_count;
   logic                      done;
   logic                      ok;
   logic [ByteWidth-1:0]      rd_byte;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign csr_ready = 1'b1;

   // one millisecond step of a timed wait
   always_comb begin
      expired    = 1'b0;
      tick_count = countdown_ff;
      if (item_ff.ms_tick) begin
         if (countdown_ff <= TimeoutWidth'(1)) begin
            expired    = 1'b1;
            tick_count = '0;
         end else begin
            tick_count = countdown_ff - TimeoutWidth'(1);
         end
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      countdown_in = countdown_ff;
      strobe_in    = strobe_ff;
      autofeed_in  = autofeed_ff;
      drive_in     = drive_ff;
      out_byte_in  = out_byte_ff;
      pending_in   = pending_ff;
      done         = 1'b0;
      ok           = 1'b0;
      rd_byte      = '0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (item_ff.kind == KindRead) begin
               strobe_in    = 1'b0;
               autofeed_in  = 1'b0;
               countdown_in = timeout_ff;
               phase_in     = PH_R_BUSY_HI;
            end else if (item_ff.kind == KindWrite) begin
               strobe_in    = 1'b1;
               autofeed_in  = 1'b0;
               drive_in     = 1'b1;
               pending_in   = item_ff.write_byte;
               countdown_in = timeout_ff;
               phase_in     = PH_W_ACK_HI;
            end
         end
         PH_R_BUSY_HI: begin
            if (item_ff.busy_line) begin
               drive_in    = 1'b0;
               autofeed_in = 1'b1;
               phase_in    = PH_R_BUSY_LO;
            end else begin
               countdown_in = tick_count;
               if (expired) begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_R_BUSY_LO: begin
            if (!item_ff.busy_line) begin
               rd_byte     = item_ff.data_in;
               autofeed_in = 1'b0;
               done        = 1'b1;
               ok          = 1'b1;
               phase_in    = PH_IDLE;
            end
         end
         PH_W_ACK_HI: begin
            if (item_ff.ack_line) begin
               out_byte_in  = pending_ff;
               strobe_in    = 1'b0;
               countdown_in = timeout_ff;
               phase_in     = PH_W_ACK_LO;
            end else begin
               countdown_in = tick_count;
               if (expired) begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_W_ACK_LO: begin
            if (!item_ff.ack_line) begin
               done     = 1'b1;
               ok       = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               countdown_in = tick_count;
               if (expired) begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      rsp_in.strobe_out   = strobe_in;
      rsp_in.autofeed_out = autofeed_in;
      rsp_in.data_drive   = drive_in;
      rsp_in.data_out     = out_byte_in;
      rsp_in.done_res     = done;
      rsp_in.success      = ok;
      rsp_in.read_result  = rd_byte;
      rsp_in.in_progress  = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         countdown_ff  <= '0;
         strobe_ff     <= 1'b0;
         autofeed_ff   <= 1'b0;
         drive_ff      <= 1'b0;
         out_byte_ff   <= '0;
         pending_ff    <= '0;
         timeout_ff    <= TimeoutReset;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_timeout_ms;
         end
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (advance) begin
            phase_ff     <= phase_in;
            countdown_ff <= countdown_in;
            strobe_ff    <= strobe_in;
            autofeed_ff  <= autofeed_in;
            drive_ff     <= drive_in;
            out_byte_ff  <= out_byte_in;
            pending_ff   <= pending_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.kind       <= req_kind;
         item_ff.write_byte <= req_write_byte;
         item_ff.ms_tick    <= req_ms_tick;
         item_ff.busy_line  <= req_busy_line;
         item_ff.ack_line   <= req_ack_line;
         item_ff.data_in    <= req_data_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_strobe_out   = rsp_ff.strobe_out;
   assign rsp_autofeed_out = rsp_ff.autofeed_out;
   assign rsp_data_drive   = rsp_ff.data_drive;
   assign rsp_data_out     = rsp_ff.data_out;
   assign rsp_done_res     = rsp_ff.done_res;
   assign rsp_success      = rsp_ff.success;
   assign rsp_read_result  = rsp_ff.read_result;
   assign rsp_in_progress  = rsp_ff.in_progress;

`ifndef SYNTHESIS
   a_success_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.success |-> rsp_ff.done_res && !rsp_ff.in_progress)
      else $error("success reported without end of transfer");

   a_write_drives_port: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_W_ACK_HI || phase_ff == PH_W_ACK_LO) |-> drive_ff)
      else $error("data port released during a write");

   a_read_autofeed: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_R_BUSY_LO) |-> autofeed_ff && !drive_ff && !strobe_ff)
      else $error("control lines wrong while waiting for BUSY low");

   a_state_holds_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(countdown_ff))
      else $error("handshake state moved without a transaction");
`endif

endmodule

### dv/tb_parallel_port_handshake_unit.sv
`timescale 1ns / 1ps

module tb_parallel_port_handshake_unit;
   import pph_pkg::*;

   localparam kind_type KindSpare = 2'd3;

   typedef enum logic [2:0] {
      PORT_IDLE,
      PORT_READ_WAIT_BUSY,
      PORT_READ_WAIT_RELEASE,
      PORT_WRITE_WAIT_ACK,
      PORT_WRITE_WAIT_RELEASE
   } port_phase_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   kind_type                req_kind = KindSample;
   logic [ByteWidth-1:0]    req_write_byte = '0;
   logic                    req_ms_tick = 1'b0;
   logic                    req_busy_line = 1'b0;
   logic                    req_ack_line = 1'b0;
   logic [ByteWidth-1:0]    req_data_in = '0;

   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_strobe_out;
   logic                    rsp_autofeed_out;
   logic                    rsp_data_drive;
   logic [ByteWidth-1:0]    rsp_data_out;
   logic                    rsp_done_res;
   logic                    rsp_success;
   logic [ByteWidth-1:0]    rsp_read_result;
   logic                    rsp_in_progress;

   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [TimeoutWidth-1:0] csr_timeout_ms = '0;

   // predicted engine state
   port_phase_type          port_phase = PORT_IDLE;
   logic [TimeoutWidth-1:0] timeout_q = TimeoutReset;
   logic [TimeoutWidth-1:0] countdown_q = '0;
   logic                    strobe_q = 1'b0;
   logic                    autofeed_q = 1'b0;
   logic                    drive_q = 1'b0;
   logic [ByteWidth-1:0]    out_byte_q = '0;
   logic [ByteWidth-1:0]    pending_byte_q = '0;

   result_type              expected_lines[$];

   int unsigned req_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int          rsp_hold_left = 0;
   int          fail_count = 0;
   int          results_checked = 0;
   int          samples_sent = 0;
   int          reads_done = 0;
   int          writes_done = 0;
   int          expirations = 0;
   int          timeout_settings = 0;

   parallel_port_handshake_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_write_byte   (req_write_byte),
      .req_ms_tick      (req_ms_tick),
      .req_busy_line    (req_busy_line),
      .req_ack_line     (req_ack_line),
      .req_data_in      (req_data_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_strobe_out   (rsp_strobe_out),
      .rsp_autofeed_out (rsp_autofeed_out),
      .rsp_data_drive   (rsp_data_drive),
      .rsp_data_out     (rsp_data_out),
      .rsp_done_res     (rsp_done_res),
      .rsp_success      (rsp_success),
      .rsp_read_result  (rsp_read_result),
      .rsp_in_progress  (rsp_in_progress),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_timeout_ms   (csr_timeout_ms)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("parallel_port_handshake_unit verification failed");
      $finish;
   end

   // one millisecond step of a timed wait, true when the wait runs out
   function automatic logic tick_expires(logic tick);
      if (!tick) return 1'b0;
      if (countdown_q <= 1) begin
         countdown_q = '0;
         expirations++;
         return 1'b1;
      end
      countdown_q = countdown_q - 1'b1;
      return 1'b0;
   endfunction

   function automatic result_type predict_port_lines(item_type it);
      result_type r;
      logic fin;
      logic ok;
      logic [ByteWidth-1:0] rd;
      fin = 1'b0;
      ok = 1'b0;
      rd = '0;
      case (port_phase)
         PORT_IDLE: begin
            if (it.kind == KindRead) begin
               strobe_q = 1'b0;
               autofeed_q = 1'b0;
               countdown_q = timeout_q;
               port_phase = PORT_READ_WAIT_BUSY;
            end else if (it.kind == KindWrite) begin
               strobe_q = 1'b1;
               autofeed_q = 1'b0;
               drive_q = 1'b1;
               pending_byte_q = it.write_byte;
               countdown_q = timeout_q;
               port_phase = PORT_WRITE_WAIT_ACK;
            end
         end
         PORT_READ_WAIT_BUSY: begin
            if (it.busy_line) begin
               drive_q = 1'b0;
               autofeed_q = 1'b1;
               port_phase = PORT_READ_WAIT_RELEASE;
            end else if (tick_expires(it.ms_tick)) begin
               fin = 1'b1;
               port_phase = PORT_IDLE;
            end
         end
         PORT_READ_WAIT_RELEASE: begin
            if (!it.busy_line) begin
               rd = it.data_in;
               autofeed_q = 1'b0;
               fin = 1'b1;
               ok = 1'b1;
               reads_done++;
               port_phase = PORT_IDLE;
            end
         end
         PORT_WRITE_WAIT_ACK: begin
            if (it.ack_line) begin
               out_byte_q = pending_byte_q;
               strobe_q = 1'b0;
               countdown_q = timeout_q;
               port_phase = PORT_WRITE_WAIT_RELEASE;
            end else if (tick_expires(it.ms_tick)) begin
               fin = 1'b1;
               port_phase = PORT_IDLE;
            end
         end
         PORT_WRITE_WAIT_RELEASE: begin
            if (!it.ack_line) begin
               fin = 1'b1;
               ok = 1'b1;
               writes_done++;
               port_phase = PORT_IDLE;
            end else if (tick_expires(it.ms_tick)) begin
               fin = 1'b1;
               port_phase = PORT_IDLE;
            end
         end
         default: port_phase = PORT_IDLE;
      endcase
      r.strobe_out   = strobe_q;
      r.autofeed_out = autofeed_q;
      r.data_drive   = drive_q;
      r.data_out     = out_byte_q;
      r.done_res     = fin;
      r.success      = ok;
      r.read_result  = rd;
      r.in_progress  = (port_phase != PORT_IDLE);
      return r;
   endfunction

   function automatic item_type port_sample(kind_type k, logic [ByteWidth-1:0] wb, logic tick,
                                            logic busy, logic ack, logic [ByteWidth-1:0] din);
      item_type it;
      it.kind       = k;
      it.write_byte = wb;
      it.ms_tick    = tick;
      it.busy_line  = busy;
      it.ack_line   = ack;
      it.data_in    = din;
      return it;
   endfunction

   // mostly well-formed handshakes with random content, some pure noise
   function automatic item_type pick_port_sample();
      item_type it;
      int unsigned roll;
      it.kind       = kind_type'($urandom_range(3));
      it.write_byte = ByteWidth'($urandom);
      it.ms_tick    = ($urandom_range(2) == 0);
      it.busy_line  = 1'($urandom);
      it.ack_line   = 1'($urandom);
      it.data_in    = ByteWidth'($urandom);
      roll = $urandom_range(99);
      if (roll < 10) return it;
      case (port_phase)
         PORT_IDLE: begin
            if (roll < 52) it.kind = KindRead;
            else if (roll < 94) it.kind = KindWrite;
         end
         PORT_READ_WAIT_BUSY:     it.busy_line = ($urandom_range(3) == 0);
         PORT_READ_WAIT_RELEASE:  it.busy_line = ($urandom_range(3) != 0);
         PORT_WRITE_WAIT_ACK:     it.ack_line  = ($urandom_range(3) == 0);
         PORT_WRITE_WAIT_RELEASE: it.ack_line  = ($urandom_range(3) != 0);
         default: ;
      endcase
      return it;
   endfunction

   task automatic send_port_sample(input item_type it);
      int gap;
      gap = 0;
      while (gap < 60 && $urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= it.kind;
      req_write_byte <= it.write_byte;
      req_ms_tick    <= it.ms_tick;
      req_busy_line  <= it.busy_line;
      req_ack_line   <= it.ack_line;
      req_data_in    <= it.data_in;
      do @(posedge clock); while (!req_ready);
      expected_lines.push_back(predict_port_lines(it));
      samples_sent++;
   endtask

   task automatic drain_port();
      req_valid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
   endtask

   // drive the awaited line levels until the running transfer completes
   task automatic settle_port_engine();
      while (port_phase != PORT_IDLE)
         send_port_sample(port_sample(KindSample, ByteWidth'($urandom), 1'b0,
                                      port_phase == PORT_READ_WAIT_BUSY,
                                      port_phase == PORT_WRITE_WAIT_ACK,
                                      ByteWidth'($urandom)));
   endtask

   task automatic program_timeout(input logic [TimeoutWidth-1:0] value);
      settle_port_engine();
      drain_port();
      repeat (4) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_timeout_ms <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      timeout_q = value;
      timeout_settings++;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      req_idle_pct  = (mode == IDLE_SENDER)   ? 84 : (mode == IDLE_BOTH) ? 34 : 0;
      rsp_stall_pct = (mode == IDLE_RECEIVER) ? 84 : (mode == IDLE_BOTH) ? 34 : 0;
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         fail_count++;
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_lines.size() == 0) begin
            fail_count++;
            $error("rsp transaction with nothing expected");
         end else begin
            want = expected_lines.pop_front();
            check_field("strobe_out", want.strobe_out, rsp_strobe_out);
            check_field("autofeed_out", want.autofeed_out, rsp_autofeed_out);
            check_field("data_drive", want.data_drive, rsp_data_drive);
            check_field("data_out", want.data_out, rsp_data_out);
            check_field("done_res", want.done_res, rsp_done_res);
            check_field("success", want.success, rsp_success);
            check_field("read_result", want.read_result, rsp_read_result);
            check_field("in_progress", want.in_progress, rsp_in_progress);
            results_checked++;
         end
      end
   end

   task automatic test_read_handshake();
      // lines sampled with the command are ignored
      send_port_sample(port_sample(KindRead,   8'h00, 1'b1, 1'b1, 1'b1, 8'h00));
      send_port_sample(port_sample(KindSample, 8'hFF, 1'b1, 1'b0, 1'b0, 8'hFF));
      // write command while busy is ignored
      send_port_sample(port_sample(KindWrite,  8'hA5, 1'b0, 1'b1, 1'b0, 8'h00));
      send_port_sample(port_sample(KindSpare,  8'h00, 1'b1, 1'b1, 1'b1, 8'h5A));
      send_port_sample(port_sample(KindSample, 8'h00, 1'b0, 1'b0, 1'b1, 8'hFF));
      // unused kind in idle acts as a plain sample
      send_port_sample(port_sample(KindSpare,  8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF));
      send_port_sample(port_sample(KindRead,   8'hFF, 1'b0, 1'b0, 1'b0, 8'hFF));
      send_port_sample(port_sample(KindSample, 8'h00, 1'b0, 1'b1, 1'b0, 8'hFF));
      send_port_sample(port_sample(KindSample, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
   endtask

   task automatic test_write_handshake();
      send_port_sample(port_sample(KindWrite,  8'hFF, 1'b0, 1'b1, 1'b1, 8'h00));
      // read command while busy is ignored
      send_port_sample(port_sample(KindRead,   8'h00, 1'b1, 1'b0, 1'b0, 8'hFF));
      send_port_sample(port_sample(KindSample, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00));
      send_port_sample(port_sample(KindSample, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00));
      send_port_sample(port_sample(KindSample, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
      send_port_sample(port_sample(KindWrite,  8'h00, 1'b0, 1'b0, 1'b1, 8'h00));
      send_port_sample(port_sample(KindSample, 8'hFF, 1'b0, 1'b0, 1'b1, 8'h00));
      send_port_sample(port_sample(KindSample, 8'hFF, 1'b0, 1'b1, 1'b0, 8'hFF));
   endtask

   task automatic test_timeout_edges();
      // zero timeout behaves like one
      program_timeout('0);
      send_port_sample(port_sample(KindRead,   8'h00, 1'b0, 1'b0, 1'b0, 8'h00));
      send_port_sample(port_sample(KindSample, 8'h00, 1'b1, 1'b0, 1'b1, 8'h00));
      send_port_sample(port_sample(KindWrite,  8'h3C, 1'b0, 1'b0, 1'b0, 8'h00));
      send_port_sample(port_sample(KindSample, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00));
      send_port_sample(port_sample(KindSample, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00));
      // fresh timeout while waiting for ack release
      program_timeout(16'd2);
      send_port_sample(port_sample(KindWrite,  8'hC3, 1'b1, 1'b0, 1'b0, 8'h00));
      send_port_sample(port_sample(KindSample, 8'h00, 1'b1, 1'b0, 1'b1, 8'h00));
      send_port_sample(port_sample(KindSample, 8'h00, 1'b1, 1'b0, 1'b1, 8'h00));
      send_port_sample(port_sample(KindSample, 8'h00, 1'b1, 1'b0, 1'b1, 8'h00));
   endtask

   task automatic test_random_traffic(input logic [TimeoutWidth-1:0] tmo,
                                      input idle_mode_type mode, input int count);
      program_timeout(tmo);
      set_idling(mode);
      repeat (count) send_port_sample(pick_port_sample());
   endtask

   task automatic test_backpressure();
      set_idling(IDLE_NONE);
      rsp_hold_left = 150;
      repeat (40) send_port_sample(pick_port_sample());
      // sender waits for every outstanding transaction
      drain_port();
      repeat (30) send_port_sample(pick_port_sample());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_read_handshake();
      test_write_handshake();
      test_timeout_edges();
      test_random_traffic(16'd1, IDLE_NONE, 150);
      test_random_traffic(16'hFFFF, IDLE_SENDER, 150);
      test_random_traffic(TimeoutWidth'($urandom_range(12, 3)), IDLE_RECEIVER, 200);
      test_random_traffic('0, IDLE_BOTH, 150);
      test_backpressure();
      test_random_traffic(16'd2, IDLE_NONE, 200);
      test_random_traffic(TimeoutWidth'($urandom_range(12, 3)), IDLE_SENDER, 150);
      test_random_traffic(TimeoutReset, IDLE_RECEIVER, 120);
      test_random_traffic(TimeoutWidth'($urandom_range(6, 1)), IDLE_BOTH, 260);
      drain_port();
      repeat (10) @(posedge clock);
      $display("%0d port samples sent, %0d results checked over %0d timeout settings",
               samples_sent, results_checked, timeout_settings);
      $display("%0d reads and %0d writes completed, %0d transfers timed out",
               reads_done, writes_done, expirations);
      if (fail_count == 0) begin
         $display("parallel_port_handshake_unit verification clean");
      end else begin
         $display("parallel_port_handshake_unit verification failed");
      end
      $finish;
   end

endmodule
